>>> rtl/bcif_pkg.sv
// Package for the block corner interpolation fill.
// Holds the block kind codes, field widths and parameter defaults.
// Used by every module under rtl.
package bcif_pkg;

  localparam int GRAY_W            = 8;
  localparam int DEF_MAX_SPAN_BITS = 8;
  localparam int QUOT_W            = 8;
  localparam int DIV_BITS_PER_STG  = 2;
  localparam int DIV_STAGES        = QUOT_W / DIV_BITS_PER_STG;

  typedef enum logic [1:0] {
    KIND_RECT  = 2'd0,
    KIND_HLINE = 2'd1,
    KIND_VLINE = 2'd2,
    KIND_POINT = 2'd3
  } kind_t;

endpackage

>>> rtl/bcif_front.sv
// Front stages of the corner interpolation fill: axis clamp, kind remap, weights.
// Depends on bcif_pkg.
module bcif_front #(
  parameter int MAX_SPAN_BITS = bcif_pkg::DEF_MAX_SPAN_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [1:0]                     block_kind,
  input  logic [MAX_SPAN_BITS-1:0]       col_span,
  input  logic [MAX_SPAN_BITS-1:0]       row_span,
  input  logic [MAX_SPAN_BITS-1:0]       col_offset,
  input  logic [MAX_SPAN_BITS-1:0]       row_offset,
  input  logic [bcif_pkg::GRAY_W-1:0]    gray_a,
  input  logic [bcif_pkg::GRAY_W-1:0]    gray_b,
  input  logic [bcif_pkg::GRAY_W-1:0]    gray_c,
  input  logic [bcif_pkg::GRAY_W-1:0]    gray_d,
  output logic                           out_valid,
  output logic [2*MAX_SPAN_BITS-1:0]     wt_a,
  output logic [2*MAX_SPAN_BITS-1:0]     wt_b,
  output logic [2*MAX_SPAN_BITS-1:0]     wt_c,
  output logic [2*MAX_SPAN_BITS-1:0]     wt_d,
  output logic [2*MAX_SPAN_BITS-1:0]     den,
  output logic [bcif_pkg::GRAY_W-1:0]    g_a,
  output logic [bcif_pkg::GRAY_W-1:0]    g_b,
  output logic [bcif_pkg::GRAY_W-1:0]    g_c,
  output logic [bcif_pkg::GRAY_W-1:0]    g_d
);
  import bcif_pkg::*;

  localparam int S    = MAX_SPAN_BITS;
  localparam int WT_W = 2 * MAX_SPAN_BITS;

  logic [S-1:0]      cw, cx, rh, ry;
  logic [S-1:0]      w_next, x_next, h_next, y_next;
  logic [GRAY_W-1:0] gc_next, gd_next, gb_next;

  logic              valid1;
  logic [S-1:0]      w1, x1, h1, y1;
  logic [GRAY_W-1:0] ga1, gb1, gc1, gd1;

  logic [S-1:0]      wx, hy;

  // Clamp offsets to spans; a zero span turns into span one, offset zero.
  always_comb begin
    if (col_span == '0) begin
      cw = S'(1);
      cx = '0;
    end else begin
      cw = col_span;
      cx = (col_offset > col_span) ? col_span : col_offset;
    end
    if (row_span == '0) begin
      rh = S'(1);
      ry = '0;
    end else begin
      rh = row_span;
      ry = (row_offset > row_span) ? row_span : row_offset;
    end
  end

  // Fold every kind onto the rectangle form.
  always_comb begin
    w_next  = cw;
    x_next  = cx;
    h_next  = rh;
    y_next  = ry;
    gb_next = gray_b;
    gc_next = gray_c;
    gd_next = gray_d;
    case (kind_t'(block_kind))
      KIND_RECT: begin
      end
      KIND_HLINE: begin
        h_next  = S'(1);
        y_next  = '0;
        gc_next = gray_a;
        gd_next = gray_b;
      end
      KIND_VLINE: begin
        w_next  = S'(1);
        x_next  = '0;
        gc_next = gray_b;
        gd_next = gray_b;
      end
      KIND_POINT: begin
        w_next  = S'(1);
        x_next  = '0;
        h_next  = S'(1);
        y_next  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else begin
      valid1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    w1  <= w_next;
    x1  <= x_next;
    h1  <= h_next;
    y1  <= y_next;
    ga1 <= gray_a;
    gb1 <= gb_next;
    gc1 <= gc_next;
    gd1 <= gd_next;
  end

  assign wx = w1 - x1;
  assign hy = h1 - y1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    wt_a <= WT_W'(wx) * WT_W'(hy);
    wt_b <= WT_W'(x1) * WT_W'(hy);
    wt_c <= WT_W'(wx) * WT_W'(y1);
    wt_d <= WT_W'(x1) * WT_W'(y1);
    den  <= WT_W'(w1) * WT_W'(h1);
    g_a  <= ga1;
    g_b  <= gb1;
    g_c  <= gc1;
    g_d  <= gd1;
  end

endmodule

>>> rtl/bcif_mac.sv
// Gray-times-weight products and their sum, two register stages.
// Depends on bcif_pkg.
module bcif_mac #(
  parameter int MAX_SPAN_BITS = bcif_pkg::DEF_MAX_SPAN_BITS
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  input  logic [2*MAX_SPAN_BITS-1:0]               wt_a,
  input  logic [2*MAX_SPAN_BITS-1:0]               wt_b,
  input  logic [2*MAX_SPAN_BITS-1:0]               wt_c,
  input  logic [2*MAX_SPAN_BITS-1:0]               wt_d,
  input  logic [2*MAX_SPAN_BITS-1:0]               den_in,
  input  logic [bcif_pkg::GRAY_W-1:0]              g_a,
  input  logic [bcif_pkg::GRAY_W-1:0]              g_b,
  input  logic [bcif_pkg::GRAY_W-1:0]              g_c,
  input  logic [bcif_pkg::GRAY_W-1:0]              g_d,
  output logic                                     out_valid,
  output logic [2*MAX_SPAN_BITS+bcif_pkg::GRAY_W-1:0] num,
  output logic [2*MAX_SPAN_BITS-1:0]               den_out
);
  import bcif_pkg::*;

  localparam int WT_W  = 2 * MAX_SPAN_BITS;
  localparam int NUM_W = WT_W + GRAY_W;

  logic              valid3;
  logic [NUM_W-1:0]  t_a, t_b, t_c, t_d;
  logic [WT_W-1:0]   den3;
  logic [NUM_W+1:0]  sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid3    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      valid3    <= in_valid;
      out_valid <= valid3;
    end
  end

  always_ff @(posedge clk) begin
    t_a  <= NUM_W'(g_a) * NUM_W'(wt_a);
    t_b  <= NUM_W'(g_b) * NUM_W'(wt_b);
    t_c  <= NUM_W'(g_c) * NUM_W'(wt_c);
    t_d  <= NUM_W'(g_d) * NUM_W'(wt_d);
    den3 <= den_in;
  end

  // Weights add up to the denominator, so the sum never exceeds NUM_W bits.
  assign sum = (NUM_W+2)'(t_a) + (NUM_W+2)'(t_b) + (NUM_W+2)'(t_c) + (NUM_W+2)'(t_d);

  always_ff @(posedge clk) begin
    num     <= sum[NUM_W-1:0];
    den_out <= den3;
  end

endmodule

>>> rtl/bcif_div_stage.sv
// One restoring-division stage: retires two quotient bits per cycle.
// Depends on bcif_pkg.
module bcif_div_stage #(
  parameter int MAX_SPAN_BITS = bcif_pkg::DEF_MAX_SPAN_BITS,
  parameter int HI_BIT        = bcif_pkg::QUOT_W - 1
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  input  logic [2*MAX_SPAN_BITS+bcif_pkg::GRAY_W-1:0] rem_in,
  input  logic [2*MAX_SPAN_BITS-1:0]                  den_in,
  input  logic [bcif_pkg::QUOT_W-1:0]                 quot_in,
  output logic                                        out_valid,
  output logic [2*MAX_SPAN_BITS+bcif_pkg::GRAY_W-1:0] rem_out,
  output logic [2*MAX_SPAN_BITS-1:0]                  den_out,
  output logic [bcif_pkg::QUOT_W-1:0]                 quot_out
);
  import bcif_pkg::*;

  localparam int NUM_W  = 2 * MAX_SPAN_BITS + GRAY_W;
  localparam int LO_BIT = HI_BIT - 1;

  logic [NUM_W-1:0]  d_hi, d_lo, r_mid, r_next;
  logic [QUOT_W-1:0] q_next;

  assign d_hi = NUM_W'(den_in) << HI_BIT;
  assign d_lo = NUM_W'(den_in) << LO_BIT;

  always_comb begin
    q_next = quot_in;
    r_mid  = rem_in;
    if (rem_in >= d_hi) begin
      r_mid          = rem_in - d_hi;
      q_next[HI_BIT] = 1'b1;
    end
    r_next = r_mid;
    if (r_mid >= d_lo) begin
      r_next         = r_mid - d_lo;
      q_next[LO_BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem_out  <= r_next;
    den_out  <= den_in;
    quot_out <= q_next;
  end

endmodule

>>> rtl/block_corner_interpolation_fill.sv
// Top level of the block corner interpolation fill.
// Depends on bcif_pkg, bcif_front, bcif_mac and bcif_div_stage.
//
// Usage: drive one pixel request (kind, spans, offsets, corner grays) and
// raise start; the request word is taken at each rising edge where start is
// high and busy is low. busy stays low, so a new word may enter every cycle.
// Once the word has passed every stage, the answer sits on pixel_value
// for exactly one cycle with done high; the receiver takes it at the edge
// that ends that cycle and has no way to hold it off.
// Throughput: one word per cycle. The path holds one clamp stage,
// two multiply stages, one sum stage and four divider stages of two
// quotient bits each.
// Reset (rst, synchronous) clears every stage valid bit; requests in flight
// are dropped and no done follows them.
// Rectangles are interpolated bilinearly; lines and points are folded onto
// the same rectangle datapath with a unit span on the unused axis.
module block_corner_interpolation_fill #(
  parameter int MAX_SPAN_BITS = bcif_pkg::DEF_MAX_SPAN_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  block_kind,
  input  logic [MAX_SPAN_BITS-1:0]    col_span,
  input  logic [MAX_SPAN_BITS-1:0]    row_span,
  input  logic [MAX_SPAN_BITS-1:0]    col_offset,
  input  logic [MAX_SPAN_BITS-1:0]    row_offset,
  input  logic [bcif_pkg::GRAY_W-1:0] gray_a,
  input  logic [bcif_pkg::GRAY_W-1:0] gray_b,
  input  logic [bcif_pkg::GRAY_W-1:0] gray_c,
  input  logic [bcif_pkg::GRAY_W-1:0] gray_d,
  output logic                        done,
  output logic [bcif_pkg::GRAY_W-1:0] pixel_value
);
  import bcif_pkg::*;

  localparam int WT_W    = 2 * MAX_SPAN_BITS;
  localparam int NUM_W   = WT_W + GRAY_W;
  localparam int LATENCY = 4 + DIV_STAGES;

  logic              accept;

  logic              f_valid;
  logic [WT_W-1:0]   wt_a, wt_b, wt_c, wt_d, f_den;
  logic [GRAY_W-1:0] g_a, g_b, g_c, g_d;

  logic              div_valid [0:DIV_STAGES];
  logic [NUM_W-1:0]  div_rem   [0:DIV_STAGES];
  logic [WT_W-1:0]   div_den   [0:DIV_STAGES];
  logic [QUOT_W-1:0] div_quot  [0:DIV_STAGES];

  // The pipeline never stalls, so requests are always taken.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Clamp and remap, then corner weights and denominator.
  bcif_front #(
    .MAX_SPAN_BITS(MAX_SPAN_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .block_kind(block_kind),
    .col_span  (col_span),
    .row_span  (row_span),
    .col_offset(col_offset),
    .row_offset(row_offset),
    .gray_a    (gray_a),
    .gray_b    (gray_b),
    .gray_c    (gray_c),
    .gray_d    (gray_d),
    .out_valid (f_valid),
    .wt_a      (wt_a),
    .wt_b      (wt_b),
    .wt_c      (wt_c),
    .wt_d      (wt_d),
    .den       (f_den),
    .g_a       (g_a),
    .g_b       (g_b),
    .g_c       (g_c),
    .g_d       (g_d)
  );

  // Weighted sum of the corner grays forms the numerator.
  bcif_mac #(
    .MAX_SPAN_BITS(MAX_SPAN_BITS)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .wt_a     (wt_a),
    .wt_b     (wt_b),
    .wt_c     (wt_c),
    .wt_d     (wt_d),
    .den_in   (f_den),
    .g_a      (g_a),
    .g_b      (g_b),
    .g_c      (g_c),
    .g_d      (g_d),
    .out_valid(div_valid[0]),
    .num      (div_rem[0]),
    .den_out  (div_den[0])
  );

  // The numerator stays below 256 times the denominator, so an 8-bit
  // quotient is exact; start it at zero and fill two bits per stage, MSB first.
  assign div_quot[0] = '0;

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    bcif_div_stage #(
      .MAX_SPAN_BITS(MAX_SPAN_BITS),
      .HI_BIT       (QUOT_W - 1 - DIV_BITS_PER_STG * i)
    ) u_div (
      .clk      (clk),
      .rst      (rst),
      .in_valid (div_valid[i]),
      .rem_in   (div_rem[i]),
      .den_in   (div_den[i]),
      .quot_in  (div_quot[i]),
      .out_valid(div_valid[i+1]),
      .rem_out  (div_rem[i+1]),
      .den_out  (div_den[i+1]),
      .quot_out (div_quot[i+1])
    );
  end

  // Present the floor quotient for one cycle with its strobe.
  assign done        = div_valid[DIV_STAGES];
  assign pixel_value = div_quot[DIV_STAGES];

  // Every accepted word produces done once it has passed every stage.
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("accepted word did not produce done on time");

  // No done without a matching accepted word.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("done without an accepted word");

  // A single point returns its start gray untouched.
  a_point_value: assert property (@(posedge clk) disable iff (rst)
    (done && $past(accept && (block_kind == KIND_POINT), LATENCY))
      |-> (pixel_value == $past(gray_a, LATENCY)))
    else $error("single point did not return gray_a");

  // The top-left corner of a rectangle returns gray_a.
  a_corner_value: assert property (@(posedge clk) disable iff (rst)
    (done && $past(accept && (block_kind == KIND_RECT) && (col_offset == '0)
                   && (row_offset == '0), LATENCY))
      |-> (pixel_value == $past(gray_a, LATENCY)))
    else $error("rectangle corner did not return gray_a");

endmodule

>>> tb/pixel_fill_checker.sv
// Checker for the block corner interpolation fill.
// It watches the request and answer channels, predicts each pixel value and compares it.
// It depends on bcif_pkg.
module pixel_fill_checker #(
  parameter int SPAN_W = bcif_pkg::DEF_MAX_SPAN_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [1:0]                  block_kind,
  input  logic [SPAN_W-1:0]           col_span,
  input  logic [SPAN_W-1:0]           row_span,
  input  logic [SPAN_W-1:0]           col_offset,
  input  logic [SPAN_W-1:0]           row_offset,
  input  logic [bcif_pkg::GRAY_W-1:0] gray_a,
  input  logic [bcif_pkg::GRAY_W-1:0] gray_b,
  input  logic [bcif_pkg::GRAY_W-1:0] gray_c,
  input  logic [bcif_pkg::GRAY_W-1:0] gray_d,
  input  logic                        done,
  input  logic [bcif_pkg::GRAY_W-1:0] pixel_value,
  output int unsigned                 fail_count,
  output int unsigned                 pending_count,
  output int unsigned                 words_taken,
  output int unsigned                 words_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import bcif_pkg::*;

  typedef struct {
    int unsigned         index;
    kind_t               kind;
    logic [GRAY_W-1:0]   value;
  } pixel_guess_t;

  pixel_guess_t pending_pixels[$];

  // Floor of the rational interpolation form.
  // Clamp each offset to its span, and treat a zero span as a unit span with offset zero.
  function automatic logic [GRAY_W-1:0] interp_pixel(
    input kind_t kind,
    input logic [SPAN_W-1:0] cs, rs, co, ro,
    input logic [GRAY_W-1:0] a, b, c, d
  );
    longint unsigned w, h, x, y, ga, gb, gc, gd, num, den;
    w = cs;
    h = rs;
    x = (co > cs) ? cs : co;
    y = (ro > rs) ? rs : ro;
    if (w == 0) begin
      w = 1;
      x = 0;
    end
    if (h == 0) begin
      h = 1;
      y = 0;
    end
    ga = a;
    gb = b;
    gc = c;
    gd = d;
    case (kind)
      KIND_POINT: begin
        num = ga;
        den = 1;
      end
      KIND_HLINE: begin
        num = ga * (w - x) + gb * x;
        den = w;
      end
      KIND_VLINE: begin
        num = ga * (h - y) + gb * y;
        den = h;
      end
      default: begin
        num = ga * (w - x) * (h - y) + gb * x * (h - y)
            + gc * (w - x) * y + gd * x * y;
        den = w * h;
      end
    endcase
    return GRAY_W'(num / den);
  endfunction

  task automatic log_failure(input string what);
    fail_count++;
    if (fail_count <= 10)
      $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Counters start at zero as int variables; only this block updates them.
  always @(posedge clk) begin
    pixel_guess_t g;
    if (!rst) begin
      if (done) begin
        if (pending_pixels.size() == 0) begin
          log_failure($sformatf("pixel_value %0d with no request pending", pixel_value));
        end else begin
          g = pending_pixels.pop_front();
          words_checked++;
          if (pixel_value !== g.value)
            log_failure($sformatf("request %0d kind %s: expected %0d, got %0d",
                                  g.index, g.kind.name(), g.value, pixel_value));
        end
      end
      if (start && !busy) begin
        g.index = words_taken;
        g.kind  = kind_t'(block_kind);
        g.value = interp_pixel(kind_t'(block_kind), col_span, row_span, col_offset,
                               row_offset, gray_a, gray_b, gray_c, gray_d);
        pending_pixels.push_back(g);
        words_taken++;
      end
      pending_count = pending_pixels.size();
    end
  end

endmodule

>>> tb/tb.sv
// Testbench top for the block corner interpolation fill.
// It drives pixel requests into u_top and gives the verdict.
// It depends on bcif_pkg, the block under test and pixel_fill_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bcif_pkg::*;

  localparam int SPAN_W      = DEF_MAX_SPAN_BITS;
  localparam int SPAN_MAX    = (1 << SPAN_W) - 1;
  localparam int GRAY_MAX    = (1 << GRAY_W) - 1;
  localparam int RAND_WORDS  = 1930;
  // Keep the final stretch back-to-back so the pipeline runs full at the end.
  localparam int QUIET_TAIL  = 200;
  // Even with the longest gaps between words, this leaves a wide margin.
  localparam int CYCLE_LIMIT = 200000;
  localparam int LATENCY     = 8;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          block_kind = '0;
  logic [SPAN_W-1:0]   col_span = '0;
  logic [SPAN_W-1:0]   row_span = '0;
  logic [SPAN_W-1:0]   col_offset = '0;
  logic [SPAN_W-1:0]   row_offset = '0;
  logic [GRAY_W-1:0]   gray_a = '0;
  logic [GRAY_W-1:0]   gray_b = '0;
  logic [GRAY_W-1:0]   gray_c = '0;
  logic [GRAY_W-1:0]   gray_d = '0;
  logic                done;
  logic [GRAY_W-1:0]   pixel_value;

  int unsigned fail_count, pending_count, words_taken, words_checked;
  int unsigned cycle_count = 0;
  int unsigned directed_words = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  block_corner_interpolation_fill #(.MAX_SPAN_BITS(SPAN_W)) u_top (
    .clk, .rst, .start, .busy, .block_kind, .col_span, .row_span,
    .col_offset, .row_offset, .gray_a, .gray_b, .gray_c, .gray_d,
    .done, .pixel_value
  );

  pixel_fill_checker #(.SPAN_W(SPAN_W)) u_checker (
    .clk, .rst, .start, .busy, .block_kind, .col_span, .row_span,
    .col_offset, .row_offset, .gray_a, .gray_b, .gray_c, .gray_d,
    .done, .pixel_value, .fail_count, .pending_count, .words_taken,
    .words_checked
  );

  // Guard against a hang: stop the run once the cycle budget is spent.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d answers pending", cycle_count, pending_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Present one request word at the falling edge, hold it while busy is high,
  // and return after the rising edge that accepts it. busy only moves on rising
  // edges, so its value at the falling edge decides the next acceptance.
  task automatic send_word(input kind_t kind,
                           input logic [SPAN_W-1:0] cs, rs, co, ro,
                           input logic [GRAY_W-1:0] a, b, c, d);
    @(negedge clk);
    start      = 1'b1;
    block_kind = kind;
    col_span   = cs;
    row_span   = rs;
    col_offset = co;
    row_offset = ro;
    gray_a     = a;
    gray_b     = b;
    gray_c     = c;
    gray_d     = d;
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  // Drop start for the idle stretch that n gives and toss random values on the fields.
  // The block has to ignore them.
  task automatic idle_for(input int n);
    repeat (n) begin
      @(negedge clk);
      start      = 1'b0;
      block_kind = 2'($urandom);
      col_span   = SPAN_W'($urandom);
      row_span   = SPAN_W'($urandom);
      col_offset = SPAN_W'($urandom);
      row_offset = SPAN_W'($urandom);
      gray_a     = GRAY_W'($urandom);
      gray_b     = GRAY_W'($urandom);
      gray_c     = GRAY_W'($urandom);
      gray_d     = GRAY_W'($urandom);
    end
  endtask

  // Most spans are short, like real decoded blocks.
  // Others are zero or random over the full range.
  function automatic logic [SPAN_W-1:0] pick_span();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 70) return SPAN_W'($urandom_range(1, 15));
    return SPAN_W'($urandom_range(0, SPAN_MAX));
  endfunction

  // Mostly pick an offset inside the span; sometimes use any value, so the clamp gets exercised.
  function automatic logic [SPAN_W-1:0] pick_offset(input logic [SPAN_W-1:0] span);
    if ($urandom_range(0, 99) < 80) return SPAN_W'($urandom_range(0, span));
    return SPAN_W'($urandom_range(0, SPAN_MAX));
  endfunction

  task automatic send_directed(input kind_t kind,
                               input logic [SPAN_W-1:0] cs, rs, co, ro,
                               input logic [GRAY_W-1:0] a, b, c, d);
    send_word(kind, cs, rs, co, ro, a, b, c, d);
    directed_words++;
  endtask

  initial begin
    kind_t             k;
    logic [SPAN_W-1:0] cs, rs;
    bit                bursty;

    // Hold reset at the start, then release it at a falling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: extremes, every kind, the exact corners and the special cases.
    send_directed(KIND_RECT, '0, '0, '0, '0, '0, '0, '0, '0);
    send_directed(KIND_RECT, SPAN_MAX, SPAN_MAX, SPAN_MAX, SPAN_MAX,
                  GRAY_MAX, GRAY_MAX, GRAY_MAX, GRAY_MAX);
    // The four corners of a rectangle give their own gray values exactly.
    send_directed(KIND_RECT, 7, 5, 0, 0, 10, 200, 77, 255);
    send_directed(KIND_RECT, 7, 5, 7, 0, 10, 200, 77, 255);
    send_directed(KIND_RECT, 7, 5, 0, 5, 10, 200, 77, 255);
    send_directed(KIND_RECT, 7, 5, 7, 5, 10, 200, 77, 255);
    // The center of a saddle rounds down.
    send_directed(KIND_RECT, 2, 2, 1, 1, 0, 255, 255, 0);
    // A zero column span collapses onto the left edge.
    send_directed(KIND_RECT, 0, 4, 3, 2, 40, 90, 160, 250);
    // With both spans zero, the block returns the top-left value.
    send_directed(KIND_RECT, 0, 0, 9, 9, 123, 1, 2, 3);
    // Offsets past the span clamp to the far edge.
    send_directed(KIND_RECT, 3, 3, 200, 9, 1, 254, 128, 66);
    send_directed(KIND_RECT, SPAN_MAX, SPAN_MAX, 1, SPAN_MAX - 1, 255, 0, 0, 255);
    // Horizontal line: start, end, middle, falling ramp, zero span, clamp.
    send_directed(KIND_HLINE, 9, 0, 0, 0, 20, 220, 0, 0);
    send_directed(KIND_HLINE, 9, 0, 9, 0, 20, 220, 0, 0);
    send_directed(KIND_HLINE, 9, 3, 4, 2, 20, 220, 255, 255);
    send_directed(KIND_HLINE, SPAN_MAX, 0, 128, 0, 255, 0, 0, 0);
    send_directed(KIND_HLINE, 0, 7, 5, 3, 99, 200, 0, 0);
    send_directed(KIND_HLINE, 6, 0, SPAN_MAX, 0, 3, 250, 0, 0);
    // Vertical line: it must follow the row axis and ignore the column fields.
    send_directed(KIND_VLINE, 12, 9, 7, 0, 20, 220, 0, 0);
    send_directed(KIND_VLINE, 12, 9, 7, 9, 20, 220, 0, 0);
    send_directed(KIND_VLINE, 0, 5, 0, 2, 200, 7, 255, 255);
    send_directed(KIND_VLINE, 5, 0, 3, 4, 77, 200, 0, 0);
    send_directed(KIND_VLINE, 1, SPAN_MAX, 1, SPAN_MAX, 0, 255, 0, 0);
    // Single point: all other fields are don't-cares.
    send_directed(KIND_POINT, SPAN_MAX, SPAN_MAX, SPAN_MAX, SPAN_MAX,
                  GRAY_MAX, 0, 0, 0);
    send_directed(KIND_POINT, 3, 4, 1, 2, 0, GRAY_MAX, GRAY_MAX, GRAY_MAX);

    // Random: switch between bursty and back-to-back stretches every 64 words.
    // Drop all gaps in the last stretch.
    bursty = 1'b0;
    for (int i = 0; i < RAND_WORDS; i++) begin
      if (i % 64 == 0) bursty = ($urandom_range(0, 2) != 0);
      if (bursty && i < RAND_WORDS - QUIET_TAIL && $urandom_range(0, 99) < 35)
        idle_for($urandom_range(1, 11));
      k  = kind_t'($urandom_range(0, 3));
      cs = pick_span();
      rs = pick_span();
      send_word(k, cs, rs, pick_offset(cs), pick_offset(rs),
                GRAY_W'($urandom), GRAY_W'($urandom),
                GRAY_W'($urandom), GRAY_W'($urandom));
    end

    // Lower start, drain the pipeline, then wait on so that a stray answer is caught.
    @(negedge clk);
    start = 1'b0;
    for (int guard = 0; guard < 100 * LATENCY && pending_count != 0; guard++)
      @(posedge clk);
    repeat (3 * LATENCY) @(posedge clk);

    $display("Sent %0d pixel requests (%0d directed, the rest random) over all four kinds,",
             words_taken, directed_words);
    $display("with zero, clamped and full-width spans; checked %0d answers, %0d errors.",
             words_checked, fail_count);
    if (pending_count != 0)
      $display("%0d requests never got an answer", pending_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
